FILE: hdl/conv3_pkg.sv
`timescale 1ns / 1ps

package conv3_pkg;

    // Default sizes of the line memory, frame and coefficient fields
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_COEF_BITS  = 12;

    localparam int SIZE_BITS      = 11;
    localparam int SHIFT_BITS     = 4;
    localparam int PIXEL_BITS     = 8;
    localparam int CFG_INDEX_BITS = 3;

    // Result queue depth; also the number of results the block may owe at once
    localparam int OUT_FIFO_DEPTH = 8;

    localparam logic [SIZE_BITS-1:0]  SIZE_RESET       = 11'd1024;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET      = 4'd8;
    localparam int                    MIDDLE_TAP_RESET = 256;
    localparam logic [PIXEL_BITS-1:0] PIXEL_MAX        = 8'hFF;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_COEF_TOP_ROW    = 3'd2,
        REG_COEF_MIDDLE_ROW = 3'd3,
        REG_COEF_BOTTOM_ROW = 3'd4,
        REG_FRAC_SHIFT      = 3'd5
    } cfg_index_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_type_t;

endpackage

FILE: hdl/conv3x3_zero_pad_filter_unit.sv
`timescale 1ns / 1ps
// 3x3 convolution with zero padding over a raster-order grayscale stream.
// Input beats (s_*): one pixel per beat; s_tuser marks a drain beat that pushes
// the last results of a finished frame out once no more pixels follow.
// Result beats (m_*): filtered pixel in m_tdata, m_tlast on the frame's last one.
// Config beats (cfg_*): register index plus data; a width or height write
// restarts the stream. cfg_ready is high only while no item is in flight.
// A pixel's result is owed once W+1 further pixels (W = row width) have come
// in; it then passes through the line memory read, the nine multipliers, the
// adder tree and the shift and clamp into the result queue, from which it
// shows on m_tvalid. The input takes one beat per cycle while s_tready is
// high; the read-modify-write of the line memory forwards the
// entry being written when the next pixel reads the same column.
// Results wait in an 8-entry queue. s_tready drops only when 8 results are
// owed (in the pipeline plus queued), so a stalled receiver holds the input
// back without losing anything, and the input never waits on m_tready directly.
// Reset clears positions, counters, the window and all valid state and loads
// the register defaults; the line memory is not cleared and needs no pass.
module conv3x3_zero_pad_filter_unit #(
    parameter int MAX_WIDTH  = conv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = conv3_pkg::DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = conv3_pkg::DEF_COEF_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [conv3_pkg::PIXEL_BITS-1:0]     s_tdata,   // [7:0] pixel_in
    input  logic                                 s_tuser,   // [0] req_type
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [conv3_pkg::PIXEL_BITS-1:0]     m_tdata,   // [7:0] pixel_out
    output logic                                 m_tlast,   // frame_last
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [conv3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [3*COEF_BITS-1:0]               cfg_data
);

    localparam int KW  = 3 * COEF_BITS;             // one kernel row register
    localparam int CB  = $clog2(MAX_WIDTH);         // column / memory address
    localparam int WB  = $clog2(MAX_WIDTH + 1);     // effective width value
    localparam int XB  = WB + 1;                    // column compare width
    localparam int RB  = $clog2(MAX_HEIGHT);        // row
    localparam int HB  = $clog2(MAX_HEIGHT + 1);    // effective height value
    localparam int YB  = HB + 1;                    // row compare width
    localparam int PB  = $clog2(MAX_WIDTH + 3);     // pending count
    localparam int PW  = COEF_BITS + 9;             // one product
    localparam int RW  = PW + 2;                    // one row sum
    localparam int SW  = PW + 4;                    // full sum
    localparam int PXB = conv3_pkg::PIXEL_BITS;
    localparam int MB  = 2 * PXB;                   // memory word: {upper, lower}
    localparam int QD  = conv3_pkg::OUT_FIFO_DEPTH;
    localparam int QA  = $clog2(QD);
    localparam int QC  = $clog2(QD + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [conv3_pkg::SIZE_BITS-1:0]  width_reg;
    logic [conv3_pkg::SIZE_BITS-1:0]  height_reg;
    logic [KW-1:0]                    coef_reg [3];
    logic [conv3_pkg::SHIFT_BITS-1:0] shift_reg;

    logic cfg_we;
    logic restart;
    logic busy;

    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_ready = !busy;
    assign restart   = cfg_we &&
                       ((cfg_index == conv3_pkg::REG_IMAGE_WIDTH) ||
                        (cfg_index == conv3_pkg::REG_IMAGE_HEIGHT));

    // Clamp the size registers to 1..MAX
    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WB'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HB'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = HB'(MAX_HEIGHT);
        end else begin
            h_eff = HB'(height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stream position state
    // ------------------------------------------------------------------
    logic [CB-1:0] in_col_reg,  in_col_next;
    logic [RB-1:0] in_row_reg,  in_row_next;
    logic [CB-1:0] out_col_reg, out_col_next;
    logic [RB-1:0] out_row_reg, out_row_next;
    logic [PB-1:0] pend_reg,    pend_next;
    logic          drain_on_reg, drain_on_next;

    logic [QC-1:0] credit_reg, credit_next;

    logic s_accept;
    logic m_pop;
    logic is_drain;

    assign s_tready = (credit_reg < QC'(QD));
    assign s_accept = s_tvalid && s_tready;
    assign m_pop    = m_tvalid && m_tready;
    assign is_drain = (s_tuser == conv3_pkg::REQ_DRAIN);

    // Decisions made as the beat is taken
    logic [CB-1:0] oc_b;
    logic [RB-1:0] or_b;
    logic [PB-1:0] pend_b;
    logic          drain_go;
    logic          act;       // window shifts
    logic          emit;      // beat completes a result
    logic [CB-1:0] rd_addr;
    logic [2:0]    rok;
    logic [2:0]    cok;
    logic          last_flag;

    always_comb begin
        logic [XB-1:0] ic_inc;
        logic [YB-1:0] ir_inc;
        logic [XB-1:0] oc_inc;
        logic [YB-1:0] or_inc;
        logic [XB-1:0] vc_inc;

        drain_go = (pend_reg != '0) && (in_col_reg == '0) && (in_row_reg == '0);

        // An unfinished drain is dropped when a pixel arrives
        if (!is_drain && drain_on_reg) begin
            pend_b = '0;
            oc_b   = in_col_reg;
            or_b   = in_row_reg;
        end else begin
            pend_b = pend_reg;
            oc_b   = out_col_reg;
            or_b   = out_row_reg;
        end

        act  = !is_drain || drain_go;
        emit = is_drain ? drain_go : (pend_b >= PB'(w_eff) + PB'(1));

        // Drain reads the column right of the result position
        vc_inc = XB'(out_col_reg) + XB'(1);
        if (is_drain) begin
            rd_addr = (vc_inc >= XB'(w_eff)) ? '0 : CB'(vc_inc);
        end else begin
            rd_addr = in_col_reg;
        end

        // Border masks for the result position
        oc_inc    = XB'(oc_b) + XB'(1);
        or_inc    = YB'(or_b) + YB'(1);
        rok       = {or_inc < YB'(h_eff), 1'b1, or_b != '0};
        cok       = {oc_inc < XB'(w_eff), 1'b1, oc_b != '0};
        last_flag = (or_inc == YB'(h_eff)) && (oc_inc == XB'(w_eff));

        // Advance the input position on pixels
        ic_inc      = XB'(in_col_reg) + XB'(1);
        ir_inc      = YB'(in_row_reg) + YB'(1);
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (!is_drain) begin
            if (ic_inc >= XB'(w_eff)) begin
                in_col_next = '0;
                in_row_next = (ir_inc >= YB'(h_eff)) ? '0 : RB'(ir_inc);
            end else begin
                in_col_next = CB'(ic_inc);
            end
        end

        // Advance the result position on emitted results
        out_col_next = oc_b;
        out_row_next = or_b;
        if (emit) begin
            if (oc_inc >= XB'(w_eff)) begin
                out_col_next = '0;
                out_row_next = (or_inc >= YB'(h_eff)) ? '0 : RB'(or_inc);
            end else begin
                out_col_next = CB'(oc_inc);
            end
        end

        pend_next = pend_b + PB'(!is_drain) - PB'(emit);

        if (!is_drain) begin
            drain_on_next = 1'b0;
        end else if (drain_go) begin
            drain_on_next = (pend_next != '0);
        end else begin
            drain_on_next = drain_on_reg;
        end
    end

    // Results owed: in flight plus queued
    always_comb begin
        credit_next = credit_reg + QC'(s_accept && emit) - QC'(m_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= conv3_pkg::SIZE_RESET;
            height_reg   <= conv3_pkg::SIZE_RESET;
            coef_reg[0]  <= '0;
            coef_reg[1]  <= KW'(conv3_pkg::MIDDLE_TAP_RESET) << COEF_BITS;
            coef_reg[2]  <= '0;
            shift_reg    <= conv3_pkg::SHIFT_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pend_reg     <= '0;
            drain_on_reg <= 1'b0;
            credit_reg   <= '0;
        end else begin
            credit_reg <= credit_next;
            if (restart) begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                pend_reg     <= '0;
                drain_on_reg <= 1'b0;
            end else if (s_accept && act) begin
                in_col_reg   <= in_col_next;
                in_row_reg   <= in_row_next;
                out_col_reg  <= out_col_next;
                out_row_reg  <= out_row_next;
                pend_reg     <= pend_next;
                drain_on_reg <= drain_on_next;
            end
            if (cfg_we) begin
                case (conv3_pkg::cfg_index_t'(cfg_index))
                    conv3_pkg::REG_IMAGE_WIDTH: begin
                        width_reg <= cfg_data[conv3_pkg::SIZE_BITS-1:0];
                    end
                    conv3_pkg::REG_IMAGE_HEIGHT: begin
                        height_reg <= cfg_data[conv3_pkg::SIZE_BITS-1:0];
                    end
                    conv3_pkg::REG_COEF_TOP_ROW: begin
                        coef_reg[0] <= cfg_data;
                    end
                    conv3_pkg::REG_COEF_MIDDLE_ROW: begin
                        coef_reg[1] <= cfg_data;
                    end
                    conv3_pkg::REG_COEF_BOTTOM_ROW: begin
                        coef_reg[2] <= cfg_data;
                    end
                    conv3_pkg::REG_FRAC_SHIFT: begin
                        shift_reg <= cfg_data[conv3_pkg::SHIFT_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Line memory: entry per column holds {two rows up, one row up}
    // ------------------------------------------------------------------
    logic [MB-1:0] line_mem [MAX_WIDTH];
    logic [MB-1:0] mem_q_reg;

    logic          s1_act_reg;
    logic          s1_write_reg;
    logic          s1_emit_reg;
    logic [CB-1:0] s1_addr_reg;
    logic [PXB-1:0] s1_pix_reg;
    logic [2:0]    s1_rok_reg;
    logic [2:0]    s1_cok_reg;
    logic          s1_last_reg;
    logic          s1_fwd_hit_reg;
    logic [MB-1:0] s1_fwd_data_reg;

    logic [MB-1:0] s1_entry;
    logic [MB-1:0] s1_wr_data;

    // Take the entry written last cycle when the same column is read again
    assign s1_entry   = s1_fwd_hit_reg ? s1_fwd_data_reg : mem_q_reg;
    assign s1_wr_data = {s1_entry[PXB-1:0], s1_pix_reg};

    always_ff @(posedge aclk) begin
        if (s1_write_reg) begin
            line_mem[s1_addr_reg] <= s1_wr_data;
        end
        if (s_accept) begin
            mem_q_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_act_reg   <= 1'b0;
            s1_write_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end else begin
            s1_act_reg   <= s_accept && act && !restart;
            s1_write_reg <= s_accept && !is_drain && !restart;
            s1_emit_reg  <= s_accept && emit && !restart;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_addr_reg     <= rd_addr;
            s1_pix_reg      <= is_drain ? '0 : s_tdata;
            s1_rok_reg      <= rok;
            s1_cok_reg      <= cok;
            s1_last_reg     <= last_flag;
            s1_fwd_hit_reg  <= s1_write_reg && (s1_addr_reg == rd_addr);
            s1_fwd_data_reg <= s1_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Window and products
    // ------------------------------------------------------------------
    logic [PXB-1:0]        win_reg  [9];
    logic [PXB-1:0]        win_next [9];
    logic signed [PW-1:0]  prod_next [9];
    logic signed [PW-1:0]  prod_reg  [9];
    logic                  s2_valid_reg;
    logic                  s2_last_reg;

    always_comb begin
        logic [PXB-1:0] ncol [3];
        ncol[0] = s1_entry[MB-1:PXB];
        ncol[1] = s1_entry[PXB-1:0];
        ncol[2] = s1_pix_reg;
        for (int i = 0; i < 9; i++) begin
            win_next[i] = win_reg[i];
        end
        if (s1_act_reg) begin
            for (int r = 0; r < 3; r++) begin
                win_next[r*3]   = win_reg[r*3+1];
                win_next[r*3+1] = win_reg[r*3+2];
                win_next[r*3+2] = ncol[r];
            end
        end
    end

    always_comb begin
        logic signed [COEF_BITS-1:0] coef_v;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef_v = $signed(coef_reg[r][c*COEF_BITS +: COEF_BITS]);
                if (s1_rok_reg[r] && s1_cok_reg[c]) begin
                    prod_next[r*3+c] = coef_v * $signed({1'b0, win_next[r*3+c]});
                end else begin
                    prod_next[r*3+c] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Adder tree, shift, clamp
    // ------------------------------------------------------------------
    logic signed [RW-1:0] rsum_reg [3];
    logic                 s3_valid_reg;
    logic                 s3_last_reg;
    logic signed [SW-1:0] total_reg;
    logic                 s4_valid_reg;
    logic                 s4_last_reg;
    logic signed [SW-1:0] shifted;
    logic [PXB-1:0]       clamped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_emit_reg) begin
            for (int i = 0; i < 9; i++) begin
                prod_reg[i] <= prod_next[i];
            end
            s2_last_reg <= s1_last_reg;
        end
        if (s2_valid_reg) begin
            for (int r = 0; r < 3; r++) begin
                rsum_reg[r] <= RW'(prod_reg[r*3]) + RW'(prod_reg[r*3+1])
                             + RW'(prod_reg[r*3+2]);
            end
            s3_last_reg <= s2_last_reg;
        end
        if (s3_valid_reg) begin
            total_reg   <= SW'(rsum_reg[0]) + SW'(rsum_reg[1]) + SW'(rsum_reg[2]);
            s4_last_reg <= s3_last_reg;
        end
    end

    // Arithmetic shift rounds toward minus infinity
    always_comb begin
        shifted = total_reg >>> shift_reg;
        if (shifted < 0) begin
            clamped = '0;
        end else if (shifted > SW'(conv3_pkg::PIXEL_MAX)) begin
            clamped = conv3_pkg::PIXEL_MAX;
        end else begin
            clamped = shifted[PXB-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    logic [PXB:0]  fifo_mem [QD];
    logic [QA-1:0] wptr_reg;
    logic [QA-1:0] rptr_reg;
    logic [QC-1:0] fifo_cnt_reg;

    always_ff @(posedge aclk) begin
        if (s4_valid_reg) begin
            fifo_mem[wptr_reg] <= {s4_last_reg, clamped};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (s4_valid_reg) begin
                wptr_reg <= wptr_reg + QA'(1);
            end
            if (m_pop) begin
                rptr_reg <= rptr_reg + QA'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + QC'(s4_valid_reg) - QC'(m_pop);
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = fifo_mem[rptr_reg][PXB-1:0];
    assign m_tlast  = fifo_mem[rptr_reg][PXB];

    assign busy = s1_act_reg || s1_write_reg || s2_valid_reg || s3_valid_reg
               || s4_valid_reg;

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= QC'(QD))
        else $error("owed result count exceeds queue depth");

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg |-> (fifo_cnt_reg < QC'(QD)) || m_pop)
        else $error("result reaches a full queue");

    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PB'(w_eff) + PB'(1))
        else $error("pending count beyond one row plus one");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (XB'(in_col_reg) < XB'(w_eff)) && (XB'(out_col_reg) < XB'(w_eff)))
        else $error("column position outside the row");

    a_drain_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_drain && drain_go && !restart)
            |=> (drain_on_reg == (pend_reg != '0)))
        else $error("drain flag out of step with pending count");
`endif

endmodule
